/* sv/gyro_rate_deadband_integrator_defines.svh */
// Assertion macros shared by the gyro integrator RTL.
`ifndef GYRO_RATE_DEADBAND_INTEGRATOR_DEFINES_SVH
`define GYRO_RATE_DEADBAND_INTEGRATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define GRDI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define GRDI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/grdi_pkg.sv */
// Types and constants of the gyro rate deadband integrator.
package grdi_pkg;

   localparam int RATE_W         = 16;
   localparam int BAND_W         = 17;
   localparam int ANGLE_W        = 40;
   localparam int AXIS_MAX       = 3;
   localparam int ACC_WIDTH_DEF  = 40;
   localparam int AXIS_COUNT_DEF = 3;

   localparam logic [BAND_W-1:0] BAND_LIMIT = 17'h10000;
   localparam logic [15:0]       CEIL_RESET = 16'h8001;

   typedef enum logic [1:0] {
      CMD_CALIBRATE = 2'd0,
      CMD_FINISH    = 2'd1,
      CMD_INTEGRATE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [RATE_W-1:0] rate;
      logic [15:0]       ceiling;
   } axis_op_type;

endpackage

/* sv/grdi_if.sv */
// Request and response channel interfaces of the gyro integrator.
interface grdi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] x_high;
   logic [7:0] x_low;
   logic [7:0] y_high;
   logic [7:0] y_low;
   logic [7:0] z_high;
   logic [7:0] z_low;

   modport source (output valid, command, x_high, x_low, y_high, y_low, z_high, z_low,
                   input ready);
   modport sink   (input valid, command, x_high, x_low, y_high, y_low, z_high, z_low,
                   output ready);
endinterface

interface grdi_rsp_if import grdi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_x;
   logic signed [ANGLE_W-1:0] angle_y;
   logic signed [ANGLE_W-1:0] angle_z;
   logic [BAND_W-1:0]         band_x;
   logic [BAND_W-1:0]         band_y;
   logic [BAND_W-1:0]         band_z;
   logic                      is_calibrated;

   modport source (output valid, angle_x, angle_y, angle_z, band_x, band_y, band_z,
                   is_calibrated, input ready);
   modport sink   (input valid, angle_x, angle_y, angle_z, band_x, band_y, band_z,
                   is_calibrated, output ready);
endinterface

/* sv/grdi_store.sv */
// Per-axis state memory with read forwarding and reset-valid bits.
module grdi_store #(
   parameter int DEPTH  = 3,
   parameter int DATA_W = 57,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Forward a same-cycle write; unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem_ff[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/grdi_axis_update.sv */
// Per-axis update: peak tracking, deadband doubling and saturating integration.
module grdi_axis_update import grdi_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  axis_op_type          op,
   input  logic [ACC_WIDTH-1:0] acc_cur,
   input  logic [BAND_W-1:0]    band_cur,
   output logic [ACC_WIDTH-1:0] acc_next,
   output logic [BAND_W-1:0]    band_next
);

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic [BAND_W-1:0]    rate_ext;
   logic [BAND_W-1:0]    mag;
   logic [BAND_W:0]      dbl;
   logic [ACC_WIDTH:0]   sum;
   logic [ACC_WIDTH-1:0] acc_sat;
   logic                 above;

   always_comb begin
      rate_ext = {op.rate[RATE_W-1], op.rate};
      mag      = rate_ext[BAND_W-1] ? BAND_W'(~rate_ext + 17'd1) : rate_ext;
      above    = mag > band_cur;
      dbl      = {band_cur, 1'b0};
      sum      = {acc_cur[ACC_WIDTH-1], acc_cur}
               + {{(ACC_WIDTH+1-BAND_W){rate_ext[BAND_W-1]}}, rate_ext};
      // clamp when the two top bits of the sum disagree
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         acc_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = sum[ACC_WIDTH-1:0];
      end

      acc_next  = acc_cur;
      band_next = band_cur;
      unique case (op.cmd)
         CMD_CALIBRATE: begin
            if (above && (mag < {1'b0, op.ceiling})) begin
               band_next = mag;
            end
         end
         CMD_FINISH: begin
            band_next = (dbl > {1'b0, BAND_LIMIT}) ? BAND_LIMIT : dbl[BAND_W-1:0];
         end
         CMD_INTEGRATE: begin
            if (above) begin
               acc_next = acc_sat;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* sv/gyro_rate_deadband_integrator.sv */
// Top level of the three-axis gyro rate deadband integrator.
`include "gyro_rate_deadband_integrator_defines.svh"

// Each request item carries one X/Y/Z rate sample and a command (calibrate,
// finish calibration, integrate) and produces exactly one response item with
// all accumulators, bands and the calibrated flag after the update. The axes
// are handled one per cycle unless a waiting response stalls them, through
// a read-modify-write of the per-axis state memory; the next item is taken as
// the last axis of the held one issues, and a new item is taken while the
// previous response still waits. Items pass the issue and update stages and
// the output register. Reset makes all per-axis state read as zero at once.
module gyro_rate_deadband_integrator import grdi_pkg::*; #(
   parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
   parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   grdi_req_if.sink    req_if,
   grdi_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AXIS_W  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int ENTRY_W = ACC_WIDTH + BAND_W;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXIS_COUNT - 1);

   logic [15:0]         ceiling_ff;

   logic                a_valid_ff;
   logic [AXIS_W-1:0]   a_axis_ff;
   cmd_type             a_cmd_ff;
   logic [RATE_W-1:0]   a_rate_ff [AXIS_MAX];
   logic                a_last;

   logic                b_valid_ff;
   logic [AXIS_W-1:0]   b_axis_ff;
   logic                b_last_ff;
   cmd_type             b_cmd_ff;
   logic [RATE_W-1:0]   b_rate_ff;

   logic                adv;
   logic                issue;
   logic                accept;
   logic                wr_en;
   logic                rsp_load;

   logic [ENTRY_W-1:0]   rd_data;
   logic [ACC_WIDTH-1:0] acc_next;
   logic [BAND_W-1:0]    band_next;
   logic [63:0]          acc_wide;
   axis_op_type          op;

   logic [ANGLE_W-1:0]  col_angle_ff [AXIS_MAX];
   logic [BAND_W-1:0]   col_band_ff  [AXIS_MAX];
   logic [ANGLE_W-1:0]  out_angle_ff [AXIS_MAX];
   logic [BAND_W-1:0]   out_band_ff  [AXIS_MAX];
   logic                out_cal_ff;
   logic                calibrated_ff;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= CEIL_RESET;
      end else if (csr_wr_en) begin
         ceiling_ff <= csr_wr_data;
      end
   end

   // Hold everything while the finished item cannot reach the output register.
   assign adv    = !(b_valid_ff && b_last_ff && rsp_valid_ff && !rsp_if.ready);
   assign a_last = (a_axis_ff == LAST_AXIS);
   assign issue  = adv && a_valid_ff;
   assign req_if.ready = adv && (!a_valid_ff || a_last);
   assign accept = req_if.valid && req_if.ready;

   // Issue stage: walk the axes of the held item.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_axis_ff  <= '0;
      end else if (adv) begin
         if (accept) begin
            a_valid_ff <= 1'b1;
            a_axis_ff  <= '0;
         end else if (a_valid_ff && a_last) begin
            a_valid_ff <= 1'b0;
         end else if (a_valid_ff) begin
            a_axis_ff <= a_axis_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff     <= cmd_type'(req_if.command);
         a_rate_ff[0] <= {req_if.x_high, req_if.x_low};
         a_rate_ff[1] <= {req_if.y_high, req_if.y_low};
         a_rate_ff[2] <= {req_if.z_high, req_if.z_low};
      end
   end

   // Update stage: memory data arrives here in the cycle after the read.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_axis_ff <= a_axis_ff;
         b_last_ff <= a_last;
         b_cmd_ff  <= a_cmd_ff;
         b_rate_ff <= a_rate_ff[a_axis_ff];
      end
   end

   assign wr_en    = adv && b_valid_ff;
   assign rsp_load = wr_en && b_last_ff;

   grdi_store #(
      .DEPTH  (AXIS_COUNT),
      .DATA_W (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue),
      .rd_addr (a_axis_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (b_axis_ff),
      .wr_data ({acc_next, band_next})
   );

   always_comb begin
      op.cmd     = b_cmd_ff;
      op.rate    = b_rate_ff;
      op.ceiling = ceiling_ff;
   end

   grdi_axis_update #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_update (
      .op        (op),
      .acc_cur   (rd_data[ENTRY_W-1:BAND_W]),
      .band_cur  (rd_data[BAND_W-1:0]),
      .acc_next  (acc_next),
      .band_next (band_next)
   );

   assign acc_wide = {{(64-ACC_WIDTH){acc_next[ACC_WIDTH-1]}}, acc_next};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         col_angle_ff[b_axis_ff] <= acc_wide[ANGLE_W-1:0];
         col_band_ff[b_axis_ff]  <= band_next;
      end
   end

   // Output register: merge the last axis with the ones collected before.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int i = 0; i < AXIS_MAX; i++) begin
            if (i >= AXIS_COUNT) begin
               out_angle_ff[i] <= '0;
               out_band_ff[i]  <= '0;
            end else if (AXIS_W'(i) == b_axis_ff) begin
               out_angle_ff[i] <= acc_wide[ANGLE_W-1:0];
               out_band_ff[i]  <= band_next;
            end else begin
               out_angle_ff[i] <= col_angle_ff[i];
               out_band_ff[i]  <= col_band_ff[i];
            end
         end
         out_cal_ff <= calibrated_ff || (b_cmd_ff == CMD_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrated_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load && (b_cmd_ff == CMD_FINISH)) begin
            calibrated_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.angle_x       = out_angle_ff[0];
   assign rsp_if.angle_y       = out_angle_ff[1];
   assign rsp_if.angle_z       = out_angle_ff[2];
   assign rsp_if.band_x        = out_band_ff[0];
   assign rsp_if.band_y        = out_band_ff[1];
   assign rsp_if.band_z        = out_band_ff[2];
   assign rsp_if.is_calibrated = out_cal_ff;

   `GRDI_ASSERT_NOW(chk_accept_boundary, accept, !a_valid_ff || a_last, "item taken mid-walk")
   `GRDI_ASSERT_NOW(chk_load_slot, rsp_load, !rsp_valid_ff || rsp_if.ready, "response overwritten")
   `GRDI_ASSERT_NEXT(chk_cal_sticky, calibrated_ff, calibrated_ff, "calibrated flag dropped")
   `GRDI_ASSERT_NEXT(chk_issue_follow, issue, b_valid_ff && (b_axis_ff == $past(a_axis_ff)), "update stage lost an axis")
   `GRDI_ASSERT_NOW(chk_axis_range, a_valid_ff, a_axis_ff <= LAST_AXIS, "axis counter out of range")

endmodule

/* test/tb.sv */
// Self-checking testbench of the gyro rate deadband integrator: directed table, then random phases.
module tb import grdi_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ACC_BITS    = ACC_WIDTH_DEF;
   localparam int LATENCY     = AXIS_COUNT_DEF + 2;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES      = 7;
   localparam int REPORT_CAP  = 200;

   typedef enum {ROW_PREDICT, ROW_KNOWN, ROW_CEILING} row_kind_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_x;
      logic [ANGLE_W-1:0] angle_y;
      logic [ANGLE_W-1:0] angle_z;
      logic [BAND_W-1:0]  band_x;
      logic [BAND_W-1:0]  band_y;
      logic [BAND_W-1:0]  band_z;
      logic               is_calibrated;
   } gyro_reading_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       cmd;
      logic [15:0]      rx;
      logic [15:0]      ry;
      logic [15:0]      rz;
      gyro_reading_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   grdi_req_if req_if ();
   grdi_rsp_if rsp_if ();

   gyro_rate_deadband_integrator uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted copy of the block state
   logic signed [63:0] angle_acc [3];
   int                 band_peak [3];
   bit                 calibrated;
   logic [15:0]        ceiling_now;

   gyro_reading_type expected_readings [$];
   stim_row_type     directed_rows [$];

   int mismatches;
   int items_sent;
   int readings_seen;
   int finishes_sent;
   int quiet_cycles;
   bit steady;
   bit hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic gyro_reading_type advance_gyro_model(input logic [1:0] op,
                                                           input logic [15:0] rx,
                                                           input logic [15:0] ry,
                                                           input logic [15:0] rz);
      logic [15:0]        rate [3];
      logic signed [63:0] top;
      logic signed [63:0] bottom;
      logic signed [63:0] sum;
      int                 d;
      int                 mag;
      gyro_reading_type   r;
      rate[0] = rx;
      rate[1] = ry;
      rate[2] = rz;
      top    = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
      bottom = -top - 64'sd1;
      for (int i = 0; i < 3; i++) begin
         d   = int'($signed(rate[i]));
         mag = (d < 0) ? -d : d;
         case (op)
            CMD_CALIBRATE: begin
               if (mag > band_peak[i] && mag < int'(ceiling_now))
                  band_peak[i] = mag;
            end
            CMD_FINISH: begin
               band_peak[i] = (band_peak[i] * 2 > 65536) ? 65536 : band_peak[i] * 2;
            end
            CMD_INTEGRATE: begin
               if (mag > band_peak[i]) begin
                  sum = angle_acc[i] + d;
                  if (sum > top)
                     sum = top;
                  else if (sum < bottom)
                     sum = bottom;
                  angle_acc[i] = sum;
               end
            end
            default: ;
         endcase
      end
      if (op == CMD_FINISH)
         calibrated = 1'b1;
      r.angle_x       = angle_acc[0][ANGLE_W-1:0];
      r.angle_y       = angle_acc[1][ANGLE_W-1:0];
      r.angle_z       = angle_acc[2][ANGLE_W-1:0];
      r.band_x        = band_peak[0][BAND_W-1:0];
      r.band_y        = band_peak[1][BAND_W-1:0];
      r.band_z        = band_peak[2][BAND_W-1:0];
      r.is_calibrated = calibrated;
      return r;
   endfunction

   function automatic gyro_reading_type band_view(input int bx, input int by, input int bz,
                                                  input bit cal);
      gyro_reading_type r;
      r               = '0;
      r.band_x        = bx[BAND_W-1:0];
      r.band_y        = by[BAND_W-1:0];
      r.band_z        = bz[BAND_W-1:0];
      r.is_calibrated = cal;
      return r;
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [1:0] cmd,
                                   input logic [15:0] rx, input logic [15:0] ry,
                                   input logic [15:0] rz, input gyro_reading_type want = '0);
      stim_row_type row;
      row.kind = kind;
      row.cmd  = cmd;
      row.rx   = rx;
      row.ry   = ry;
      row.rz   = rz;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_ceiling(input logic [15:0] value);
      add_row(ROW_CEILING, CMD_CALIBRATE, value, 16'h0000, 16'h0000);
   endfunction

   // Mostly back to back, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Mix of full-range, near-deadband and small rates
   function automatic logic [15:0] pick_rate(input int band, input bit wide);
      int pick;
      int b;
      pick = $urandom_range(0, 9);
      if (wide && pick < 3)
         return 16'($urandom);
      if (pick < 5) begin
         b = band + int'($urandom_range(0, 2)) - 1;
         if (b < 0)
            b = 0;
         if (b > 32768)
            b = 32768;
         return ($urandom_range(0, 1) == 1) ? 16'(-b) : 16'(b);
      end
      return 16'(int'($urandom_range(0, 800)) - 400);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic offer_item(input logic [1:0] cmd, input logic [15:0] rx,
                             input logic [15:0] ry, input logic [15:0] rz,
                             input bit known, input gyro_reading_type want);
      int               gap;
      gyro_reading_type predicted;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.x_high  <= rx[15:8];
      req_if.x_low   <= rx[7:0];
      req_if.y_high  <= ry[15:8];
      req_if.y_low   <= ry[7:0];
      req_if.z_high  <= rz[15:8];
      req_if.z_low   <= rz[7:0];
      do @(posedge clock); while (!req_if.ready);
      predicted = advance_gyro_model(cmd, rx, ry, rz);
      expected_readings.push_back(known ? want : predicted);
      items_sent++;
      if (cmd == CMD_FINISH)
         finishes_sent++;
   endtask

   // Hold the input until every expected item is back
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_ceiling(input logic [15:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ceiling_now = value;
   endtask

   // Result receiver
   initial begin
      int len;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!steady && $urandom_range(0, 2) == 0) begin
            len = pick_gap();
            if (len > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (len) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      gyro_reading_type got;
      gyro_reading_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.angle_x       = rsp_if.angle_x;
         got.angle_y       = rsp_if.angle_y;
         got.angle_z       = rsp_if.angle_z;
         got.band_x        = rsp_if.band_x;
         got.band_y        = rsp_if.band_y;
         got.band_z        = rsp_if.band_z;
         got.is_calibrated = rsp_if.is_calibrated;
         readings_seen++;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t unexpected result: expected none, actual %h", $time, got);
         end else begin
            want = expected_readings.pop_front();
            check_field("angle_x", 64'(want.angle_x), 64'(got.angle_x));
            check_field("angle_y", 64'(want.angle_y), 64'(got.angle_y));
            check_field("angle_z", 64'(want.angle_z), 64'(got.angle_z));
            check_field("band_x", 64'(want.band_x), 64'(got.band_x));
            check_field("band_y", 64'(want.band_y), 64'(got.band_y));
            check_field("band_z", 64'(want.band_z), 64'(got.band_z));
            check_field("is_calibrated", 64'(want.is_calibrated), 64'(got.is_calibrated));
         end
      end
   end

   // Watchdog: end the run after too long without any handshake
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t watchdog: no item accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [1:0]  cmd;
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] rz;
      logic [15:0] ceiling;
      bit          wide;
      int          r;
      int          directed_count;

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= CEIL_RESET;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_CALIBRATE;
      req_if.x_high  <= 8'h00;
      req_if.x_low   <= 8'h00;
      req_if.y_high  <= 8'h00;
      req_if.y_low   <= 8'h00;
      req_if.z_high  <= 8'h00;
      req_if.z_low   <= 8'h00;
      steady         = 1'b0;
      hold_request   = 1'b0;
      mismatches     = 0;
      items_sent     = 0;
      readings_seen  = 0;
      finishes_sent  = 0;
      for (int i = 0; i < 3; i++) begin
         angle_acc[i] = '0;
         band_peak[i] = 0;
      end
      calibrated  = 1'b0;
      ceiling_now = CEIL_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state, unused command, first peaks
      add_row(ROW_KNOWN, CMD_UNUSED, 16'h7fff, 16'h8000, 16'h1234, band_view(0, 0, 0, 0));
      add_row(ROW_KNOWN, CMD_CALIBRATE, 16'h0000, 16'h0000, 16'h0000, band_view(0, 0, 0, 0));
      add_row(ROW_KNOWN, CMD_CALIBRATE, 16'h0010, 16'hfff0, 16'h0000,
              band_view(16, 16, 0, 0));
      // Integrate before finish, at and just past the peaks
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h7fff, 16'h8000, 16'h0001);
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h0010, 16'hfff0, 16'hffff);
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h0011, 16'hffef, 16'h0000);
      // Ceiling of zero blocks every peak update
      add_ceiling(16'h0000);
      add_row(ROW_PREDICT, CMD_CALIBRATE, 16'h0011, 16'h0001, 16'h0005);
      // Rates equal to the ceiling are left out
      add_ceiling(16'd100);
      add_row(ROW_PREDICT, CMD_CALIBRATE, 16'h0064, 16'h0063, 16'hff9c);
      add_ceiling(16'hffff);
      add_row(ROW_PREDICT, CMD_CALIBRATE, 16'h8000, 16'h0000, 16'h0003);
      add_ceiling(CEIL_RESET);
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h8000, 16'h0064, 16'hfffc);
      // Repeated finish saturates the widest band
      add_row(ROW_PREDICT, CMD_FINISH, 16'h0000, 16'h0000, 16'h0000);
      add_row(ROW_PREDICT, CMD_FINISH, 16'hffff, 16'hffff, 16'hffff);
      // Calibrate after finish keeps raising peaks
      add_row(ROW_PREDICT, CMD_CALIBRATE, 16'h0000, 16'h018d, 16'h000d);
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h7fff, 16'hfe73, 16'h000e);
      add_row(ROW_PREDICT, CMD_INTEGRATE, 16'h8000, 16'hfe72, 16'hfff3);
      add_row(ROW_PREDICT, CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CEILING)
            write_ceiling(directed_rows[i].rx);
         else
            offer_item(directed_rows[i].cmd, directed_rows[i].rx, directed_rows[i].ry,
                       directed_rows[i].rz, directed_rows[i].kind == ROW_KNOWN,
                       directed_rows[i].want);
      end
      directed_count = items_sent;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       ceiling = 16'd150;
            1:       ceiling = 16'd0;
            2:       ceiling = 16'd1;
            3:       ceiling = 16'hffff;
            4:       ceiling = 16'h8000;
            5:       ceiling = 16'($urandom_range(2, 300));
            default: ceiling = CEIL_RESET;
         endcase
         write_ceiling(ceiling);
         steady = (p == 4);
         // Stall results for a long stretch while items keep coming
         if (p == 2)
            hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 399);
            if (r == 0)
               cmd = CMD_FINISH;
            else if (r <= 20)
               cmd = CMD_UNUSED;
            else if (r <= 160)
               cmd = CMD_CALIBRATE;
            else
               cmd = CMD_INTEGRATE;
            // Keep peaks modest under a high ceiling so the deadbands stay open
            wide = !(cmd == CMD_CALIBRATE && ceiling_now > 16'd1000);
            rx = pick_rate(band_peak[0], wide);
            ry = pick_rate(band_peak[1], wide);
            rz = pick_rate(band_peak[2], wide);
            offer_item(cmd, rx, ry, rz, 1'b0, '0);
         end
         steady = 1'b0;
      end

      settle_block();
      repeat (20) @(posedge clock);
      if (expected_readings.size() != 0) begin
         mismatches += expected_readings.size();
         $display("%0t %0d results never arrived, first expected %h, actual none",
                  $time, expected_readings.size(), expected_readings[0]);
      end

      $display("Sent %0d items (%0d directed, %0d finish) and checked %0d results",
               items_sent, directed_count, finishes_sent, readings_seen);
      $display("Covered all commands over 11 ceiling writes, random stalls and a long hold");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
